### design/brle_pkg.sv
package brle_pkg;

  localparam int KEY_BITS    = 5;
  localparam int DIM_BITS    = 16;
  localparam int LEN_BITS    = 32;
  localparam int WORD_BITS   = 37;
  localparam int CBITS_W     = 6;
  localparam int CHAN_BITS   = 8;
  localparam int HDR_BITS    = 2 * DIM_BITS + 1;
  localparam int KEY_MAX     = (1 << KEY_BITS) - 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 144;

  localparam logic [CHAN_BITS-1:0] BLACK_LIMIT = CHAN_BITS'(32);
  localparam logic [DIM_BITS-1:0]  DIM_RESET   = DIM_BITS'(1);

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    ENT_HDR = 1'b0,
    ENT_RUN = 1'b1
  } ent_kind_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] white_count;
    logic [DIM_BITS-1:0] left;
    logic [DIM_BITS-1:0] right;
    logic [DIM_BITS-1:0] top;
    logic [DIM_BITS-1:0] bottom;
  } stats_t;

  // queue entry: header word, or a run length with its precomputed key
  typedef struct packed {
    ent_kind_t           kind;
    logic [HDR_BITS-1:0] data;
    logic [KEY_BITS-1:0] key;
    logic                last;
    stats_t              stats;
  } entry_t;

  typedef struct packed {
    logic   push0;
    logic   push1;
    entry_t ent0;
    entry_t ent1;
  } push_t;

  typedef struct packed {
    logic space_ok;
    logic valid;
  } qstat_t;

endpackage

### design/brle_front.sv
module brle_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [brle_pkg::DIM_BITS-1:0]        cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [brle_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  brle_pkg::qstat_t                     q_stat,
  output brle_pkg::push_t                      q_push
);

  logic [brle_pkg::DIM_BITS-1:0] width_r, height_r;
  logic [brle_pkg::LEN_BITS-1:0] size_r;
  logic                          cfg_hold_r;

  logic [brle_pkg::LEN_BITS-1:0] pix_r, pix_nxt;
  logic [brle_pkg::DIM_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic                          colour_r, colour_nxt;
  logic [brle_pkg::LEN_BITS-1:0] len_r, len_nxt;
  logic [brle_pkg::KEY_BITS-1:0] key_r, key_nxt;
  brle_pkg::stats_t              stats_r, stats_nxt;

  logic                          accept, white, first, emit0, last;
  logic [brle_pkg::LEN_BITS-1:0] len0, len1;
  logic [brle_pkg::KEY_BITS-1:0] key0, key1;
  brle_pkg::stats_t              base;
  brle_pkg::entry_t              e0, elast;

  // size product is registered; hold off input while it still lags a write
  assign in_tready = q_stat.space_ok && !cfg_hold_r;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    white = !((in_tdata[7:0] < brle_pkg::BLACK_LIMIT) &&
              (in_tdata[15:8] < brle_pkg::BLACK_LIMIT) &&
              (in_tdata[23:16] < brle_pkg::BLACK_LIMIT));
    first = (pix_r == '0);

    colour_nxt = colour_r;
    e0         = '0;
    emit0      = 1'b0;
    base       = stats_r;
    len0       = len_r;
    key0       = key_r;

    if (first) begin
      emit0         = 1'b1;
      e0.kind       = brle_pkg::ENT_HDR;
      e0.data       = {width_r, height_r, white};
      base.white_count = '0;
      base.left     = width_r;
      base.right    = '0;
      base.top      = height_r;
      base.bottom   = '0;
      colour_nxt    = white;
      len0          = '0;
      key0          = '0;
    end else if (white != colour_r) begin
      emit0         = 1'b1;
      e0.kind       = brle_pkg::ENT_RUN;
      e0.data       = {1'b0, len_r};
      e0.key        = key_r;
      colour_nxt    = white;
      len0          = '0;
      key0          = '0;
    end

    // key tracks the least k with length <= 2^k, capped at the top code
    len1 = len0 + brle_pkg::LEN_BITS'(1);
    if (len0 == '0) begin
      key1 = '0;
    end else if (({1'b0, len1} > (33'd1 << key0)) &&
                 (key0 != brle_pkg::KEY_BITS'(brle_pkg::KEY_MAX))) begin
      key1 = key0 + brle_pkg::KEY_BITS'(1);
    end else begin
      key1 = key0;
    end

    stats_nxt = base;
    if (white) begin
      stats_nxt.white_count = base.white_count + brle_pkg::LEN_BITS'(1);
      if (col_r < base.left)   stats_nxt.left   = col_r;
      if (col_r > base.right)  stats_nxt.right  = col_r;
      if (row_r < base.top)    stats_nxt.top    = row_r;
      if (row_r > base.bottom) stats_nxt.bottom = row_r;
    end

    last = (({1'b0, pix_r} + 33'd1) >= {1'b0, size_r});

    elast       = '0;
    elast.kind  = brle_pkg::ENT_RUN;
    elast.data  = {1'b0, len1};
    elast.key   = key1;
    elast.last  = 1'b1;
    elast.stats = stats_nxt;

    if (last) begin
      pix_nxt = '0;
      col_nxt = '0;
      row_nxt = '0;
      len_nxt = '0;
      key_nxt = '0;
    end else begin
      pix_nxt = pix_r + brle_pkg::LEN_BITS'(1);
      len_nxt = len1;
      key_nxt = key1;
      if (({1'b0, col_r} + 17'd1) >= {1'b0, width_r}) begin
        col_nxt = '0;
        row_nxt = row_r + brle_pkg::DIM_BITS'(1);
      end else begin
        col_nxt = col_r + brle_pkg::DIM_BITS'(1);
        row_nxt = row_r;
      end
    end

    q_push = '0;
    if (emit0) begin
      q_push.push0 = accept;
      q_push.ent0  = e0;
      q_push.push1 = accept && last;
      q_push.ent1  = elast;
    end else begin
      q_push.push0 = accept && last;
      q_push.ent0  = elast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= brle_pkg::DIM_RESET;
      height_r   <= brle_pkg::DIM_RESET;
      size_r     <= brle_pkg::LEN_BITS'(1);
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_we;
      size_r     <= brle_pkg::LEN_BITS'(width_r) * brle_pkg::LEN_BITS'(height_r);
      if (cfg_we) begin
        unique case (brle_pkg::cfg_idx_t'(cfg_index))
          brle_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
          brle_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      colour_r <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      stats_r  <= '{white_count: '0, left: brle_pkg::DIM_RESET, right: '0,
                    top: brle_pkg::DIM_RESET, bottom: '0};
    end else if (accept) begin
      pix_r    <= pix_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      colour_r <= colour_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      stats_r  <= stats_nxt;
    end
  end

endmodule

### design/brle_queue.sv
module brle_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  brle_pkg::push_t   q_push,
  input  logic              pop,
  output brle_pkg::qstat_t  q_stat,
  output brle_pkg::entry_t  head
);

  brle_pkg::entry_t               mem_r [brle_pkg::QDEPTH];
  logic [brle_pkg::QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [brle_pkg::QCNT_BITS-1:0] count_r, count_nxt;

  assign wr_ptr_p1       = wr_ptr_r + brle_pkg::QPTR_BITS'(1);
  assign head            = mem_r[rd_ptr_r];
  assign q_stat.valid    = (count_r != '0);
  // room for the two results one pixel can make
  assign q_stat.space_ok = (count_r <= brle_pkg::QCNT_BITS'(brle_pkg::QDEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (q_push.push0 && q_push.push1) begin
      wr_ptr_nxt = wr_ptr_r + brle_pkg::QPTR_BITS'(2);
    end else if (q_push.push0) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? rd_ptr_r + brle_pkg::QPTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r + brle_pkg::QCNT_BITS'(q_push.push0)
                         + brle_pkg::QCNT_BITS'(q_push.push1)
                         - brle_pkg::QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (q_push.push0) mem_r[wr_ptr_r]  <= q_push.ent0;
    if (q_push.push1) mem_r[wr_ptr_p1] <= q_push.ent1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### design/brle_back.sv
module brle_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  brle_pkg::entry_t                  head,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [brle_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  output logic [0:0]                        out_tuser
);

  logic                                 valid_r;
  logic [brle_pkg::WORD_BITS-1:0]       word_r, word_nxt;
  logic [brle_pkg::CBITS_W-1:0]         bits_r, bits_nxt;
  logic                                 last_r, err_r, err_nxt;
  brle_pkg::stats_t                     stats_r;
  logic [brle_pkg::LEN_BITS-1:0]        len;

  assign pop = q_valid && (!valid_r || out_tready);
  assign len = head.data[brle_pkg::LEN_BITS-1:0];

  always_comb begin
    if (head.kind == brle_pkg::ENT_HDR) begin
      word_nxt = brle_pkg::WORD_BITS'(head.data);
      bits_nxt = brle_pkg::CBITS_W'(brle_pkg::HDR_BITS);
      err_nxt  = 1'b0;
    end else begin
      // key in front of the length; the length always fits in key+1 bits
      word_nxt = (brle_pkg::WORD_BITS'(head.key) <<
                  (brle_pkg::CBITS_W'(head.key) + brle_pkg::CBITS_W'(1))) |
                 brle_pkg::WORD_BITS'(len);
      bits_nxt = brle_pkg::CBITS_W'(brle_pkg::KEY_BITS) + brle_pkg::CBITS_W'(head.key) +
                 brle_pkg::CBITS_W'(1);
      err_nxt  = len[brle_pkg::LEN_BITS-1] && (|len[brle_pkg::LEN_BITS-2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r  <= word_nxt;
      bits_r  <= bits_nxt;
      err_r   <= err_nxt;
      last_r  <= head.last;
      stats_r <= head.stats;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tlast    = last_r;
  assign out_tuser[0] = err_r;
  assign out_tdata    = {5'd0, stats_r.bottom, stats_r.top, stats_r.right, stats_r.left,
                         stats_r.white_count, bits_r, word_r};

endmodule

### design/bitmap_run_length_encoder_top.sv
// A pixel's results are written to the queue at its transfer and then loaded in order into the
// output register. Throughput: one pixel per cycle while the queue has room; the output port
// moves one code word per cycle while out_tready is high, so a pixel with two results (frame
// start or colour change plus frame end) takes an extra output slot.
// in_tready drops in the cycle after a config write while the frame size product updates.
// Reset: synchronous, active low; clears counters, queue and output valid, size regs to 1.
module bitmap_run_length_encoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [brle_pkg::DIM_BITS-1:0]     cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [brle_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [36:0] code_word, [42:37] code_bits, [74:43] white_count, [90:75] box_left,
  // [106:91] box_right, [122:107] box_top, [138:123] box_bottom, rest zero
  output logic [brle_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  // [0] run_error
  output logic [0:0]                        out_tuser
);

  brle_pkg::push_t  q_push;
  brle_pkg::qstat_t q_stat;
  brle_pkg::entry_t head;
  logic             pop;

  brle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  brle_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  brle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_stat.valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### design/brle_checker.sv
module brle_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tlast,
  input logic [0:0]   out_tuser
);

  // stalled code word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // frame statistics only ride with the last word
  a_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[138:43] == '0)
    else $error("statistics on a non-final word");

  a_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[42:37] >= 6'd6 && out_tdata[42:37] <= 6'd37)
    else $error("code_bits out of range");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[42:37] == 6'd37 && out_tdata[36:32] == 5'd31)
    else $error("oversize run without top key");

endmodule

bind bitmap_run_length_encoder_top brle_checker u_brle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
